FILE: src/acit_pkg.sv
// Shared types, constants and helper functions for the alpha-cut interval table.
// Depends on nothing; every other file of the block imports it.
package acit_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ALPHA_W = 17;
    localparam int BOUND_W = 32;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_ORDER    = 3'd3,
        ST_NOT_NEST = 3'd4
    } status_t;

    typedef struct packed {
        op_t                op;
        logic [ALPHA_W-1:0] alpha;
        logic [BOUND_W-1:0] left_bound;
        logic [BOUND_W-1:0] right_bound;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [BOUND_W-1:0] out_left;
        logic [BOUND_W-1:0] out_right;
        logic [4:0]         entry_count;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_SHIFT,
        S_QSEL,
        S_QRD,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

endpackage

FILE: src/acit_front.sv
// Front part: accepts input beats, clamps alpha, and holds them in a short queue.
// Depends on acit_pkg.
module acit_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  logic [1:0]     op,
    input  logic [16:0]    alpha,
    input  logic [31:0]    left_bound,
    input  logic [31:0]    right_bound,
    output logic           cmd_valid,
    input  logic           cmd_take,
    output acit_pkg::cmd_t cmd
);
    import acit_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cmd_t       in_cmd;
    logic       do_push, do_pop;

    always_comb
    begin
        in_cmd.op = op_t'(op);
        in_cmd.alpha = (alpha > ALPHA_ONE) ? ALPHA_ONE : alpha;
        in_cmd.left_bound = left_bound;
        in_cmd.right_bound = right_bound;
        full = (cnt_reg == 2'd2);
        cmd_valid = (cnt_reg != 2'd0);
        cmd = q_reg[rp_reg];
        do_push = push && !full;
        do_pop = cmd_take && cmd_valid;
        wp_next = do_push ? ~wp_reg : wp_reg;
        rp_next = do_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

FILE: src/acit_div.sv
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on acit_pkg.
module acit_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [16:0] divisor,
    output logic        busy,
    output logic [63:0] quotient
);
    import acit_pkg::*;

    logic [63:0] q_reg, q_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] den_reg, den_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic [17:0] trial;

    always_comb
    begin
        q_next = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        trial = 18'd0;
        if (start)
        begin
            neg_next = dividend[63];
            q_next = dividend[63] ? (~dividend + 64'd1) : dividend;
            rem_next = 17'd0;
            den_next = divisor;
            cnt_next = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            trial = {rem_reg, q_reg[63]};
            q_next = {q_reg[62:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 17'(trial - {1'b0, den_reg});
                q_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[16:0];
            end
            cnt_next = cnt_reg - 7'd1;
        end
        busy = (cnt_reg != 7'd0);
        quotient = neg_reg ? (~q_reg + 64'd1) : q_reg;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 7'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end
endmodule

FILE: src/acit_back.sv
// Back part: table storage, sorted insertion, bracket search and interpolation.
// Depends on acit_pkg and acit_div.
module acit_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_take,
    input  acit_pkg::cmd_t cmd,
    output logic           empty,
    input  logic           pop,
    output acit_pkg::res_t res
);
    import acit_pkg::*;

    logic [ALPHA_W-1:0] lvl_mem [TABLE_DEPTH];
    logic [BOUND_W-1:0] lft_mem [TABLE_DEPTH];
    logic [BOUND_W-1:0] rgt_mem [TABLE_DEPTH];

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   hi_reg, hi_next, lo_reg, lo_next;
    logic               side_reg, side_next;
    logic [ALPHA_W-1:0] ahi_reg, ahi_next, alo_reg, alo_next;
    logic [BOUND_W-1:0] bhi_reg, bhi_next, blo_reg, blo_next;
    logic [BOUND_W-1:0] lres_reg, lres_next;
    logic [63:0]        num_reg, num_next;
    res_t               res_reg, res_next;
    res_t               out_reg, out_next;
    logic               full_reg, full_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic [ALPHA_W-1:0] wr_lvl;
    logic [BOUND_W-1:0] wr_lft, wr_rgt;
    logic [IDX_W-1:0]   pidx, pm1;
    logic               div_start, div_busy;
    logic [63:0]        div_q;
    logic [32:0]        diff;
    logic signed [50:0] prod;
    logic [BOUND_W-1:0] interp;

    acit_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (ahi_reg - alo_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        fill_next = fill_reg;
        pos_next = pos_reg;
        hi_next = hi_reg;
        lo_next = lo_reg;
        side_next = side_reg;
        ahi_next = ahi_reg;
        alo_next = alo_reg;
        bhi_next = bhi_reg;
        blo_next = blo_reg;
        lres_next = lres_reg;
        num_next = num_reg;
        res_next = res_reg;
        out_next = out_reg;
        full_next = full_reg;
        cmd_take = 1'b0;
        wr_en = 1'b0;
        pidx = pos_reg[IDX_W-1:0];
        pm1 = pidx - 1'b1;
        wr_idx = pidx;
        wr_lvl = cmd_reg.alpha;
        wr_lft = cmd_reg.left_bound;
        wr_rgt = cmd_reg.right_bound;
        div_start = 1'b0;
        diff = {blo_reg[31], blo_reg} - {bhi_reg[31], bhi_reg};
        prod = $signed(diff) * $signed({1'b0, ahi_reg - cmd_reg.alpha});
        interp = bhi_reg + div_q[31:0];
        if (full_reg && pop)
        begin
            full_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take = 1'b1;
                    cmd_next = cmd;
                    pos_next = '0;
                    res_next.status = ST_OK;
                    res_next.out_left = '0;
                    res_next.out_right = '0;
                    case (cmd.op)
                        OP_CLEAR:
                        begin
                            fill_next = '0;
                            state_next = S_DONE;
                        end
                        OP_INSERT:
                        begin
                            if (fill_reg >= CNT_W'(TABLE_DEPTH))
                            begin
                                res_next.status = ST_FULL;
                                state_next = S_DONE;
                            end
                            else if ($signed(cmd.left_bound) > $signed(cmd.right_bound))
                            begin
                                res_next.status = ST_ORDER;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_next.status = ST_EMPTY;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cmd_reg.op == OP_INSERT)
                begin
                    if (pos_reg < fill_reg && lvl_mem[pidx] >= cmd_reg.alpha)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    if (pos_reg >= fill_reg)
                    begin
                        hi_next = fill_reg[IDX_W-1:0] - 1'b1;
                        lo_next = fill_reg[IDX_W-1:0] - 1'b1;
                        state_next = S_QRD;
                    end
                    else
                    begin
                        if (lvl_mem[pidx] >= cmd_reg.alpha)
                        begin
                            hi_next = pidx;
                        end
                        if (lvl_mem[pidx] <= cmd_reg.alpha)
                        begin
                            lo_next = pidx;
                            if (pos_reg == '0)
                            begin
                                hi_next = pidx;
                            end
                            state_next = S_QRD;
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                if ((pos_reg != '0 && ($signed(cmd_reg.left_bound) > $signed(lft_mem[pm1])
                     || $signed(cmd_reg.right_bound) < $signed(rgt_mem[pm1])))
                    || (pos_reg < fill_reg
                     && ($signed(cmd_reg.left_bound) < $signed(lft_mem[pidx])
                     || $signed(cmd_reg.right_bound) > $signed(rgt_mem[pidx]))))
                begin
                    res_next.status = ST_NOT_NEST;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next = fill_reg;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                wr_en = 1'b1;
                wr_idx = pidx;
                if (pos_reg != '0 && lvl_mem[pm1] < cmd_reg.alpha)
                begin
                    wr_lvl = lvl_mem[pm1];
                    wr_lft = lft_mem[pm1];
                    wr_rgt = rgt_mem[pm1];
                    pos_next = pos_reg - 1'b1;
                end
                else
                begin
                    fill_next = fill_reg + 1'b1;
                    state_next = S_DONE;
                end
            end
            S_QRD:
            begin
                ahi_next = lvl_mem[hi_reg];
                alo_next = lvl_mem[lo_reg];
                bhi_next = side_reg ? rgt_mem[hi_reg] : lft_mem[hi_reg];
                blo_next = side_reg ? rgt_mem[lo_reg] : lft_mem[lo_reg];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (hi_reg == lo_reg)
                begin
                    if (side_reg)
                    begin
                        res_next.out_left = lres_reg;
                        res_next.out_right = bhi_reg;
                        side_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lres_next = bhi_reg;
                        side_next = 1'b1;
                        state_next = S_QRD;
                    end
                end
                else
                begin
                    num_next = {{13{prod[50]}}, prod};
                    state_next = S_DIV;
                    pos_next = '0;
                end
            end
            S_DIV:
            begin
                if (pos_reg == '0)
                begin
                    div_start = 1'b1;
                    pos_next = CNT_W'(1);
                end
                else if (!div_busy)
                begin
                    if (side_reg)
                    begin
                        res_next.out_left = lres_reg;
                        res_next.out_right = interp;
                        side_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lres_next = interp;
                        side_next = 1'b1;
                        state_next = S_QRD;
                    end
                end
            end
            S_DONE:
            begin
                if (!full_reg || pop)
                begin
                    out_next = res_reg;
                    out_next.entry_count = 5'(fill_reg);
                    full_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        empty = !full_reg;
        res = out_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lvl_mem[wr_idx] <= wr_lvl;
            lft_mem[wr_idx] <= wr_lft;
            rgt_mem[wr_idx] <= wr_rgt;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        ahi_reg <= ahi_next;
        alo_reg <= alo_next;
        bhi_reg <= bhi_next;
        blo_reg <= blo_next;
        lres_reg <= lres_next;
        num_reg <= num_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            pos_reg <= '0;
            side_reg <= 1'b0;
            full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            pos_reg <= pos_next;
            side_reg <= side_next;
            full_reg <= full_next;
        end
    end
endmodule

FILE: src/alpha_cut_interval_table_core.sv
// Top level of the alpha-cut interval table: a front queue feeding the table engine.
// Depends on acit_pkg, acit_front and acit_back.
// A clear or a rejected insert goes straight to its result; an accepted insert scans
// the table for its place and then shifts entries down, and an interpolating query scans
// to its bracket and runs the 64-step divider once for each bound that it interpolates.
// One result beat is given per input beat, and a two-entry input queue lets the next
// item wait while a result is still unread.
module alpha_cut_interval_table_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic [16:0] alpha,
    input  logic [31:0] left_bound,
    input  logic [31:0] right_bound,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [31:0] out_left,
    output logic [31:0] out_right,
    output logic [4:0]  entry_count
);
    import acit_pkg::*;

    logic cmd_valid, cmd_take;
    cmd_t cmd;
    res_t res;

    acit_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .op          (op),
        .alpha       (alpha),
        .left_bound  (left_bound),
        .right_bound (right_bound),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .cmd         (cmd)
    );

    acit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    assign status = res.status;
    assign out_left = res.out_left;
    assign out_right = res.out_right;
    assign entry_count = res.entry_count;
endmodule
